/* rtl/core/npba_pkg.sv */
// shared types, constants and helpers of the nat port bitmap allocator
package npba_pkg;

  // bitmap geometry
  localparam int WORDS_PER_ADDR = 1024;
  localparam int WORD_W         = 64;
  localparam int WORD_IDX_W     = 10;
  localparam int RESERVED_WORDS = 16;
  localparam int SCAN_WORDS     = WORDS_PER_ADDR - RESERVED_WORDS;
  localparam int NUM_ADDRS_DEF  = 4;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;

  // request codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_ALLOCATED = 2'd0;
  localparam status_t ST_RELEASED  = 2'd1;
  localparam status_t ST_EXHAUSTED = 2'd2;
  localparam status_t ST_REJECTED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST_ADDR  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic    clr_en;      // write zero at the clear pointer
    logic    load_in;     // capture the input item
    logic    rd_port;     // read the word holding port_arg
    logic    scan_init;   // set up the fallback scan
    logic    scan_step;   // read the next scan word, check the previous one
    logic    pref_claim;  // set the preferred port bit
    logic    release_w;   // clear the port bit
    logic    scan_claim;  // set the lowest free bit of the hit word
    logic    res_fixed;   // result without a port
    status_t res_code;
    logic    out_load;    // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic req_ok;
    logic is_release;
    logic port_reserved;
    logic pref_free;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } ctrl_sts_t;

  // index of the lowest clear bit, searched by byte then by bit
  function automatic logic [5:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [7:0] grp_nf;
    logic [2:0] g;
    logic [7:0] byt;
    logic [2:0] b;
    for (int i = 0; i < 8; i++) begin
      grp_nf[i] = ~&w[i*8 +: 8];
    end
    g = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_nf[i]) g = 3'(i);
    end
    byt = w[g*8 +: 8];
    b = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!byt[i]) b = 3'(i);
    end
    return {g, b};
  endfunction

endpackage

/* rtl/core/npba_ctrl.sv */
// request sequencer of the nat port bitmap allocator
module npba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  npba_pkg::ctrl_sts_t sts,
  output npba_pkg::ctrl_cmd_t cmd
);
  import npba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DISP  = 3'd3;
  localparam logic [2:0] S_PREF  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (!sts.req_ok || (sts.is_release && sts.port_reserved)) begin
          cmd.res_fixed = 1'b1;
          cmd.res_code  = ST_REJECTED;
          state_nxt     = S_DONE;
        end else if (sts.is_release) begin
          cmd.rd_port = 1'b1;
          state_nxt   = S_PREF;
        end else begin
          cmd.scan_init = 1'b1;
          if (sts.port_reserved) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.rd_port = 1'b1;
            state_nxt   = S_PREF;
          end
        end
      end
      S_PREF: begin
        if (sts.is_release) begin
          cmd.release_w = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.pref_free) begin
          cmd.pref_claim = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.scan_claim = 1'b1;
          state_nxt      = S_DONE;
        end else if (sts.scan_end) begin
          cmd.res_fixed = 1'b1;
          cmd.res_code  = ST_EXHAUSTED;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/npba_dpath.sv */
// bitmap memory, counters, config registers and result registers
module npba_dpath #(
  parameter int NUM_ADDRS = npba_pkg::NUM_ADDRS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  npba_pkg::ctrl_cmd_t               cmd,
  output npba_pkg::ctrl_sts_t               sts,
  input  logic                              in_cmd,
  input  logic [npba_pkg::ADDR_W-1:0]       in_public_addr,
  input  logic [npba_pkg::PORT_W-1:0]       in_port_arg,
  input  logic [npba_pkg::WORD_IDX_W-1:0]   in_scan_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npba_pkg::PORT_W-1:0]       out_port_out,
  output npba_pkg::status_t                 out_status,
  output logic [npba_pkg::CNT_W-1:0]        out_allocated_total,
  output logic [npba_pkg::CNT_W-1:0]        out_released_total,
  input  logic                              cfg_wr_en,
  input  logic [npba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [npba_pkg::CFG_W-1:0]        cfg_wdata
);
  import npba_pkg::*;

  localparam int DEPTH = NUM_ADDRS * WORDS_PER_ADDR;
  localparam int AW    = $clog2(DEPTH);
  localparam int OFW   = (NUM_ADDRS > 1) ? $clog2(NUM_ADDRS) : 1;

  // bitmap memory
  logic [WORD_W-1:0] mem [DEPTH];

  // config registers
  logic              en_r;
  logic [ADDR_W-1:0] first_r;
  logic [ADDR_W-1:0] last_r;

  // captured item and address check
  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;
  logic [WORD_IDX_W-1:0] start_r;
  logic              ge_r;
  logic              le_r;
  logic [ADDR_W-1:0] diff_r;
  logic [OFW-1:0]    off;

  // clear pointer
  logic [AW-1:0] clr_cnt_r;

  // read side
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_IDX_W-1:0] rd_word_r;
  logic              sdv_r;

  // scan pointer
  logic [WORD_IDX_W-1:0] scan_word_r;
  logic [WORD_IDX_W-1:0] scan_word_nxt;
  logic [WORD_IDX_W-1:0] checked_r;

  // write side
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] pmask;
  logic [5:0]        free_bit;
  logic              word_full;

  // counters and results
  logic [CNT_W-1:0]  alloc_cnt_r;
  logic [CNT_W-1:0]  rel_cnt_r;
  logic [PORT_W-1:0] res_port_r;
  status_t           res_status_r;
  logic              out_vld_r;
  logic [PORT_W-1:0] out_port_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_alloc_r;
  logic [CNT_W-1:0]  out_rel_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      first_r <= '0;
      last_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POOL_ENABLED:    en_r    <= cfg_wdata[0];
        CFG_POOL_FIRST_ADDR: first_r <= cfg_wdata;
        CFG_POOL_LAST_ADDR:  last_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture and registered range check
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_public_addr;
      port_r  <= in_port_arg;
      start_r <= in_scan_start;
    end
    ge_r   <= addr_r >= first_r;
    le_r   <= addr_r <= last_r;
    diff_r <= addr_r - first_r;
  end

  assign off = diff_r[OFW-1:0];

  // clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // scan pointer: words 16..1023 in a ring
  always_comb begin
    if (scan_word_r == WORD_IDX_W'(WORDS_PER_ADDR - 1)) begin
      scan_word_nxt = WORD_IDX_W'(RESERVED_WORDS);
    end else begin
      scan_word_nxt = scan_word_r + WORD_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_word_r <= (start_r < WORD_IDX_W'(RESERVED_WORDS)) ?
                     WORD_IDX_W'(RESERVED_WORDS) : start_r;
      checked_r   <= '0;
    end else if (cmd.scan_step) begin
      scan_word_r <= scan_word_nxt;
      if (sdv_r) checked_r <= checked_r + WORD_IDX_W'(1);
    end
  end

  // memory read
  assign rd_en   = cmd.rd_port | cmd.scan_step;
  assign rd_addr = cmd.rd_port ? AW'({off, port_r[PORT_W-1:6]}) : AW'({off, scan_word_r});

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.scan_step) begin
      rd_word_r <= scan_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdv_r <= 1'b0;
    end else begin
      sdv_r <= cmd.scan_step;
    end
  end

  // word inspection
  assign pmask     = WORD_W'(1) << port_r[5:0];
  assign word_full = &rd_data_r;
  assign free_bit  = lowest_zero(rd_data_r);

  // memory write
  always_comb begin
    wr_en   = cmd.clr_en | cmd.pref_claim | cmd.release_w | cmd.scan_claim;
    wr_addr = AW'({off, rd_word_r});
    wr_data = rd_data_r | (WORD_W'(1) << free_bit);
    if (cmd.clr_en) begin
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.pref_claim) begin
      wr_addr = AW'({off, port_r[PORT_W-1:6]});
      wr_data = rd_data_r | pmask;
    end else if (cmd.release_w) begin
      wr_addr = AW'({off, port_r[PORT_W-1:6]});
      wr_data = rd_data_r & ~pmask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // running counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_cnt_r <= '0;
      rel_cnt_r   <= '0;
    end else begin
      if (cmd.pref_claim || cmd.scan_claim) alloc_cnt_r <= alloc_cnt_r + CNT_W'(1);
      if (cmd.release_w) rel_cnt_r <= rel_cnt_r + CNT_W'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.pref_claim) begin
      res_port_r   <= port_r;
      res_status_r <= ST_ALLOCATED;
    end else if (cmd.scan_claim) begin
      res_port_r   <= {rd_word_r, free_bit};
      res_status_r <= ST_ALLOCATED;
    end else if (cmd.release_w) begin
      res_port_r   <= '0;
      res_status_r <= ST_RELEASED;
    end else if (cmd.res_fixed) begin
      res_port_r   <= '0;
      res_status_r <= cmd.res_code;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_port_r   <= res_port_r;
      out_status_r <= res_status_r;
      out_alloc_r  <= alloc_cnt_r;
      out_rel_r    <= rel_cnt_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_port_out        = out_port_r;
  assign out_status          = out_status_r;
  assign out_allocated_total = out_alloc_r;
  assign out_released_total  = out_rel_r;

  // status to the controller
  always_comb begin
    sts.clr_last      = clr_cnt_r == AW'(DEPTH - 1);
    sts.req_ok        = en_r && ge_r && le_r && (diff_r < ADDR_W'(NUM_ADDRS));
    sts.is_release    = cmd_r == CMD_RELEASE;
    sts.port_reserved = port_r[PORT_W-1:6] < WORD_IDX_W'(RESERVED_WORDS);
    sts.pref_free     = (rd_data_r & pmask) == '0;
    sts.scan_hit      = sdv_r && !word_full;
    sts.scan_end      = sdv_r && word_full && (checked_r == WORD_IDX_W'(SCAN_WORDS - 1));
    sts.out_free      = !out_vld_r || out_ready;
  end

endmodule

/* rtl/core/nat_port_bitmap_allocator_core.sv */
// top level of the nat port bitmap allocator
//
// One request item on the in_ channel (valid/ready) gives one result item
// on the out_ channel (valid/ready). Allocate (in_cmd 0) claims the
// preferred port when it is above 1023 and free, otherwise the lowest free
// bit of the first non-full bitmap word found from in_scan_start, words
// 0..15 skipped. Release (in_cmd 1) frees a port above 1023.
// The user must write the pool registers on the cfg_ port only while no
// item is in flight; the block itself does not enforce this.
// A scan inspects up to 1008 words. One item is in work at a time and
// the next one is taken only once its result has reached the output
// register; the bitmap word scan reads one word per cycle through the
// single read port of the bitmap memory.
// After reset a clearing pass writes all NUM_ADDRS*1024 bitmap words, one
// per cycle; in_ready stays low until the pass is done.
// A result waits in the output register while out_ready is low; the next
// item is taken meanwhile and is held before its own result until the
// output register frees up.
module nat_port_bitmap_allocator_core #(
  parameter int NUM_ADDRS = npba_pkg::NUM_ADDRS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [npba_pkg::ADDR_W-1:0]     in_public_addr,
  input  logic [npba_pkg::PORT_W-1:0]     in_port_arg,
  input  logic [npba_pkg::WORD_IDX_W-1:0] in_scan_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [npba_pkg::PORT_W-1:0]     out_port_out,
  output npba_pkg::status_t               out_status,
  output logic [npba_pkg::CNT_W-1:0]      out_allocated_total,
  output logic [npba_pkg::CNT_W-1:0]      out_released_total,
  input  logic                            cfg_wr_en,
  input  logic [npba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npba_pkg::CFG_W-1:0]      cfg_wdata
);
  import npba_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  npba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap datapath
  npba_dpath #(
    .NUM_ADDRS (NUM_ADDRS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cmd              (in_cmd),
    .in_public_addr      (in_public_addr),
    .in_port_arg         (in_port_arg),
    .in_scan_start       (in_scan_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_port_out        (out_port_out),
    .out_status          (out_status),
    .out_allocated_total (out_allocated_total),
    .out_released_total  (out_released_total),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // no second item is taken right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // an allocated port never lies in the reserved range
  a_alloc_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ALLOCATED) |-> (out_port_out[15:10] != '0))
    else $error("allocated port in reserved range");

  // results without an allocation carry port zero
  a_zero_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ALLOCATED) |-> (out_port_out == '0))
    else $error("nonzero port on a result without allocation");

  // the bitmap is never touched by two commands at once
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_en, cmd.pref_claim, cmd.release_w, cmd.scan_claim}))
    else $error("conflicting bitmap writes");

endmodule
